### sv/fta_pkg.sv
// ----------------------------------------------------------------------------
// fta_pkg: shared types and constants of the fixed-timestep accumulator
// Payload structs of the frame, result and configuration channels, register
// indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package fta_pkg;

  // Field widths
  localparam int unsigned ElapsedW = 24;
  localparam int unsigned FixStepW = 21;
  localparam int unsigned ScaleW   = 11;
  localparam int unsigned FrameW   = 26;
  localparam int unsigned AccW     = 28;
  localparam int unsigned TickW    = 32;
  localparam int unsigned DropW    = 32;
  localparam int unsigned AlphaW   = 17;
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgDataW = 24;

  // Step budget per frame
  localparam int unsigned MaxSteps = 8;

  // Configuration reset values
  localparam logic [FixStepW-1:0] FixStepRst  = FixStepW'(17476);
  localparam logic [ScaleW-1:0]   ScaleRst    = ScaleW'(256);
  localparam logic [ElapsedW-1:0] MaxFrameRst = ElapsedW'(262144);

  // Time scale ceiling, 4.0 in Q3.8
  localparam logic [ScaleW-1:0] ScaleMax = ScaleW'(1024);

  // Configuration register indexes
  typedef enum logic [1:0] {
    RegFixedStep = 2'd0,
    RegTimeScale = 2'd1,
    RegPaused    = 2'd2,
    RegMaxFrame  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ElapsedW-1:0] elapsed;
    logic                single_step;
  } in_t;

  typedef struct packed {
    logic                step_granted;
    logic [TickW-1:0]    sim_ticks;
    logic [ElapsedW-1:0] real_delta;
    logic [FrameW-1:0]   frame_delta;
    logic [AlphaW-1:0]   alpha;
    logic [DropW-1:0]    dropped_time;
    logic                last;
  } out_t;

  typedef struct packed {
    cfg_reg_e            reg_idx;
    logic [CfgDataW-1:0] value;
  } cfg_t;

endpackage

### sv/fta_stream_if.sv
// ----------------------------------------------------------------------------
// fta_stream_if: valid/ready channel
// Carries one payload per transfer; source drives valid and data, sink
// drives ready.
// ----------------------------------------------------------------------------
interface fta_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### sv/fixed_timestep_accumulator.sv
// ----------------------------------------------------------------------------
// fixed_timestep_accumulator: frame tick to fixed simulation steps
// Clamps and scales the frame time, adds it to the accumulator and emits one
// result per granted step plus a final result with alpha and dropped time.
// ----------------------------------------------------------------------------
// Sequence: clamp on transfer, scale (StMul), add (StAdd), grant steps while
//   the output slot is free (StStep), modulo and dropped time when the budget
//   runs out, then alpha and the final result; no new frame is taken before
//   that, and the single shared subtractor does steps, modulo and alpha.
// Reset: accumulator, tick count and dropped total cleared, registers take
//   their defaults; the frame channel is ready right after reset.
module fixed_timestep_accumulator #(
  parameter int unsigned MAX_STEPS = fta_pkg::MaxSteps
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fta_stream_if.sink   in_if,
  fta_stream_if.source out_if,
  fta_stream_if.sink   cfg_if
);

  import fta_pkg::*;

  localparam int unsigned StepW = $clog2(MAX_STEPS + 1);
  localparam int unsigned SubW  = AccW + 1;
  localparam int unsigned RemW  = FixStepW;
  localparam int unsigned CntW  = $clog2(AccW);
  localparam int unsigned ProdW = ElapsedW + ScaleW;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StAdd,
    StStep,
    StMod,
    StDrop,
    StAlpha,
    StFinal
  } state_e;

  // Configuration registers
  logic [FixStepW-1:0] fix_step_q;
  logic [ScaleW-1:0]   scale_q;
  logic                paused_q;
  logic [ElapsedW-1:0] max_frame_q;

  // Frame state
  state_e              state_q, state_d;
  logic [ElapsedW-1:0] rd_q;
  logic                single_q;
  logic [FrameW-1:0]   fd_q;
  logic [AccW-1:0]     acc_q;
  logic [TickW-1:0]    tick_q;
  logic [DropW-1:0]    drop_q;
  logic [StepW-1:0]    steps_q;
  logic [RemW-1:0]     rem_q;
  logic [FracW-1:0]    quo_q;
  logic [CntW-1:0]     cnt_q;

  // Output register
  logic out_valid_q;
  out_t out_data_q;

  // Datapath signals
  logic [ScaleW-1:0]   scale_eff;
  logic [ProdW-1:0]    prod;
  logic [AccW:0]       acc_sum;
  logic [RemW:0]       rem_sh;
  logic [AccW-1:0]     sub_a;
  logic [SubW-1:0]     diff;
  logic                ge;
  logic [RemW-1:0]     rem_next;
  logic [AccW-1:0]     drop_amt;
  logic [DropW:0]      drop_sum;
  logic                slot_free;
  logic                step_due;
  logic                out_load;

  // Handshake ports
  assign in_if.ready  = (state_q == StIdle);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  assign slot_free = !out_valid_q || out_if.ready;

  // Scale the clamped frame time
  assign scale_eff = (scale_q > ScaleMax) ? ScaleMax : scale_q;
  assign prod      = ProdW'(rd_q) * ProdW'(scale_eff);
  assign acc_sum   = {1'b0, acc_q} + (AccW + 1)'(fd_q);

  // Shared subtract and compare unit
  always_comb begin
    rem_sh = '0;
    case (state_q)
      StMod:   rem_sh = {rem_q, acc_q[cnt_q]};
      StAlpha: rem_sh = {rem_q, 1'b0};
      default: rem_sh = '0;
    endcase
    case (state_q)
      StMod, StAlpha: sub_a = AccW'(rem_sh);
      default:        sub_a = acc_q;
    endcase
  end

  assign diff     = {1'b0, sub_a} - SubW'(fix_step_q);
  assign ge       = !diff[SubW-1];
  assign rem_next = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
  assign step_due = ge && (steps_q < StepW'(MAX_STEPS));

  // Load a new result into the output register
  assign out_load = slot_free &&
                    (((state_q == StStep) && step_due) || (state_q == StFinal));

  // Dropped time with saturation
  assign drop_amt = acc_q - AccW'(rem_q);
  assign drop_sum = {1'b0, drop_q} + (DropW + 1)'(drop_amt);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_if.valid) state_d = StMul;
      StMul:   state_d = StAdd;
      StAdd:   state_d = (fix_step_q == '0) ? StFinal : StStep;
      StStep: begin
        if (step_due) state_d = StStep;
        else if (ge)  state_d = StMod;
        else          state_d = StAlpha;
      end
      StMod:   if (cnt_q == '0) state_d = StDrop;
      StDrop:  state_d = StAlpha;
      StAlpha: if (cnt_q == '0) state_d = StFinal;
      StFinal: if (slot_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fix_step_q  <= FixStepRst;
      scale_q     <= ScaleRst;
      paused_q    <= 1'b0;
      max_frame_q <= MaxFrameRst;
      rd_q        <= '0;
      single_q    <= 1'b0;
      fd_q        <= '0;
      acc_q       <= '0;
      tick_q      <= '0;
      drop_q      <= '0;
      steps_q     <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // Take configuration writes
      if (cfg_if.valid) begin
        case (cfg_if.data.reg_idx)
          RegFixedStep: fix_step_q  <= cfg_if.data.value[FixStepW-1:0];
          RegTimeScale: scale_q     <= cfg_if.data.value[ScaleW-1:0];
          RegPaused:    paused_q    <= cfg_if.data.value[0];
          RegMaxFrame:  max_frame_q <= cfg_if.data.value[ElapsedW-1:0];
          default:      ;
        endcase
      end

      // Raise the output on a new result, drop it once it is taken
      if (out_load)          out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;

      state_q <= state_d;
      case (state_q)
        StIdle: begin
          if (in_if.valid) begin
            rd_q     <= (in_if.data.elapsed < max_frame_q) ? in_if.data.elapsed
                                                           : max_frame_q;
            single_q <= in_if.data.single_step;
          end
        end
        StMul: begin
          if (paused_q) fd_q <= single_q ? FrameW'(fix_step_q) : '0;
          else          fd_q <= prod[FrameW+7:8];
        end
        StAdd: begin
          acc_q   <= acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
          steps_q <= '0;
          quo_q   <= '0;
        end
        StStep: begin
          if (step_due) begin
            // Grant one step when the output slot is free
            if (slot_free) begin
              acc_q       <= diff[AccW-1:0];
              steps_q     <= steps_q + StepW'(1);
              tick_q      <= tick_q + TickW'(1);
              out_data_q  <= '{step_granted: 1'b1, sim_ticks: tick_q + TickW'(1),
                               real_delta: rd_q, frame_delta: fd_q, alpha: '0,
                               dropped_time: '0, last: 1'b0};
            end
          end else if (ge) begin
            rem_q <= '0;
            cnt_q <= CntW'(AccW - 1);
          end else begin
            rem_q <= acc_q[RemW-1:0];
            cnt_q <= CntW'(FracW - 1);
          end
        end
        StMod: begin
          // Restoring remainder, one accumulator bit per cycle
          rem_q <= rem_next;
          cnt_q <= cnt_q - CntW'(1);
        end
        StDrop: begin
          drop_q <= drop_sum[DropW] ? '1 : drop_sum[DropW-1:0];
          acc_q  <= AccW'(rem_q);
          cnt_q  <= CntW'(FracW - 1);
        end
        StAlpha: begin
          // Fraction of a step, one quotient bit per cycle
          rem_q <= rem_next;
          quo_q <= {quo_q[FracW-2:0], ge};
          cnt_q <= cnt_q - CntW'(1);
        end
        StFinal: begin
          if (slot_free) begin
            out_data_q  <= '{step_granted: 1'b0, sim_ticks: tick_q,
                             real_delta: rd_q, frame_delta: fd_q,
                             alpha: AlphaW'(quo_q), dropped_time: drop_q,
                             last: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  // Step count stays within the budget
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= StepW'(MAX_STEPS))
    else $error("step budget exceeded");

  // Partial remainder stays below the fixed step while alpha is formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAlpha) |-> (RemW'(rem_q) < fix_step_q))
    else $error("alpha remainder out of range");

  // Final result closes the frame and is presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinal && slot_free) |=>
      (state_q == StIdle && out_if.valid && out_if.data.last))
    else $error("final result not presented");

  // A step result is only issued from the step run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(tick_q[0]) || $fell(tick_q[0])) |-> ($past(state_q) == StStep))
    else $error("tick count advanced outside the step run");

endmodule
